// File: rtl/core/sbil_pkg.sv
// ----------------------------------------------------------------------------
// Serial boot image loader package
// Shared constants and types of the loader's front end, word queue and parser.
// ----------------------------------------------------------------------------
package sbil_pkg;

  localparam int unsigned FifoDepthDef = 4;

  localparam logic KindWrite = 1'b0;
  localparam logic KindEnd   = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
  } word_req_t;

endpackage

// File: rtl/core/sbil_byte_if.sv
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel that carries one received serial byte per request.
// ----------------------------------------------------------------------------
interface sbil_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/sbil_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries a memory write or an end-of-transfer report.
// ----------------------------------------------------------------------------
interface sbil_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] mem_addr;
  logic [31:0] mem_data;
  logic [31:0] entry_address;
  logic        pass;
  logic [31:0] local_count;
  logic [31:0] local_sum;

  modport source (output valid, output kind, output mem_addr, output mem_data,
                  output entry_address, output pass, output local_count,
                  output local_sum, input ready);
  modport sink   (input valid, input kind, input mem_addr, input mem_data,
                  input entry_address, input pass, input local_count,
                  input local_sum, output ready);
endinterface

// File: rtl/core/sbil_front.sv
// ----------------------------------------------------------------------------
// Loader front end
// Accepts serial bytes and packs each group of four into a little-endian word.
// ----------------------------------------------------------------------------
module sbil_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  sbil_byte_if.sink          rx_i,
  input  logic               full_i,
  output sbil_pkg::word_req_t push_o
);

  logic [1:0]  pos_q, pos_d;
  logic [23:0] shift_q, shift_d;
  logic        accept;

  assign rx_i.ready = (pos_q != 2'd3) || !full_i;
  assign accept     = rx_i.valid && rx_i.ready;

  always_comb begin
    pos_d   = pos_q;
    shift_d = shift_q;
    push_o  = '0;
    if (accept) begin
      pos_d = pos_q + 2'd1;
      case (pos_q)
        2'd0:    shift_d[7:0]   = rx_i.rx_byte;
        2'd1:    shift_d[15:8]  = rx_i.rx_byte;
        2'd2:    shift_d[23:16] = rx_i.rx_byte;
        default: begin
          push_o.valid = 1'b1;
          push_o.word  = {rx_i.rx_byte, shift_q};
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

endmodule

// File: rtl/core/sbil_fifo.sv
// ----------------------------------------------------------------------------
// Loader word queue
// Small first-in first-out queue of assembled words between front and parser.
// ----------------------------------------------------------------------------
module sbil_fifo #(
  parameter int unsigned FifoDepth = sbil_pkg::FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbil_pkg::word_req_t push_i,
  output logic                full_o,
  output sbil_pkg::word_req_t head_o,
  input  logic                pop_i
);

  localparam int unsigned IdxW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic [31:0]     mem_q [FifoDepth];
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign full_o      = (cnt_q == CntW'(FifoDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.word  = mem_q[rd_q];
  assign push        = push_i.valid && !full_o;
  assign pop         = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == IdxW'(FifoDepth - 1)) ? '0 : wr_q + IdxW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == IdxW'(FifoDepth - 1)) ? '0 : rd_q + IdxW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i.word;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("word queue count exceeds its depth");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("word pushed into a full queue");

endmodule

// File: rtl/core/sbil_back.sv
// ----------------------------------------------------------------------------
// Loader image parser
// Walks the boot image word by word, issues memory writes and the end report.
// ----------------------------------------------------------------------------
module sbil_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbil_pkg::word_req_t head_i,
  output logic                pop_o,
  sbil_result_if.source       res_o
);

  typedef enum logic [2:0] {
    PhEntry = 3'd0,
    PhNsect = 3'd1,
    PhAddr  = 3'd2,
    PhSize  = 3'd3,
    PhData  = 3'd4,
    PhTcnt  = 3'd5,
    PhTsum  = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] entry_q, entry_d;
  logic [31:0] sect_q, sect_d;
  logic [29:0] words_q, words_d;
  logic [31:0] wptr_q, wptr_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] scnt_q, scnt_d;

  logic        ov_q, ov_d;
  logic        okind_q, okind_d;
  logic [31:0] oaddr_q, oaddr_d;
  logic [31:0] odata_q, odata_d;
  logic [31:0] oentry_q, oentry_d;
  logic        opass_q, opass_d;
  logic [31:0] ocnt_q, ocnt_d;
  logic [31:0] osum_q, osum_d;

  logic [31:0] w;
  logic [31:0] size_rnd;

  assign w        = head_i.word;
  assign size_rnd = w + 32'd3;
  assign pop_o    = head_i.valid && (!ov_q || res_o.ready);

  always_comb begin
    phase_d  = phase_q;
    entry_d  = entry_q;
    sect_d   = sect_q;
    words_d  = words_q;
    wptr_d   = wptr_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    scnt_d   = scnt_q;
    ov_d     = ov_q && !res_o.ready;
    okind_d  = okind_q;
    oaddr_d  = oaddr_q;
    odata_d  = odata_q;
    oentry_d = oentry_q;
    opass_d  = opass_q;
    ocnt_d   = ocnt_q;
    osum_d   = osum_q;
    if (pop_o) begin
      unique case (phase_q)
        PhNsect: begin
          sum_d   = sum_q + w;
          cnt_d   = cnt_q + 32'd1;
          sect_d  = w;
          phase_d = (w == 32'd0) ? PhTcnt : PhAddr;
        end
        PhAddr: begin
          sum_d   = sum_q + w;
          cnt_d   = cnt_q + 32'd1;
          wptr_d  = w;
          phase_d = PhSize;
        end
        PhSize: begin
          sum_d = sum_q + w;
          cnt_d = cnt_q + 32'd1;
          if (w[31] || w == 32'd0) begin
            words_d = '0;
            sect_d  = sect_q - 32'd1;
            phase_d = (sect_q == 32'd1) ? PhTcnt : PhAddr;
          end else begin
            words_d = size_rnd[31:2];
            phase_d = PhData;
          end
        end
        PhData: begin
          sum_d    = sum_q + w;
          cnt_d    = cnt_q + 32'd1;
          ov_d     = 1'b1;
          okind_d  = sbil_pkg::KindWrite;
          oaddr_d  = wptr_q;
          odata_d  = w;
          oentry_d = '0;
          opass_d  = 1'b0;
          ocnt_d   = '0;
          osum_d   = '0;
          wptr_d   = wptr_q + 32'd4;
          words_d  = words_q - 30'd1;
          if (words_q == 30'd1) begin
            sect_d  = sect_q - 32'd1;
            phase_d = (sect_q == 32'd1) ? PhTcnt : PhAddr;
          end
        end
        PhTcnt: begin
          scnt_d  = w;
          phase_d = PhTsum;
        end
        PhTsum: begin
          ov_d     = 1'b1;
          okind_d  = sbil_pkg::KindEnd;
          oaddr_d  = '0;
          odata_d  = '0;
          oentry_d = entry_q;
          opass_d  = (scnt_q == cnt_q) && (w == sum_q);
          ocnt_d   = cnt_q;
          osum_d   = sum_q;
          phase_d  = PhEntry;
          sum_d    = '0;
          cnt_d    = '0;
          sect_d   = '0;
          words_d  = '0;
          scnt_d   = '0;
        end
        default: begin
          sum_d   = w;
          cnt_d   = 32'd1;
          entry_d = w;
          phase_d = PhNsect;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhEntry;
      entry_q  <= '0;
      sect_q   <= '0;
      words_q  <= '0;
      wptr_q   <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      scnt_q   <= '0;
      ov_q     <= 1'b0;
      okind_q  <= sbil_pkg::KindWrite;
      oaddr_q  <= '0;
      odata_q  <= '0;
      oentry_q <= '0;
      opass_q  <= 1'b0;
      ocnt_q   <= '0;
      osum_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      entry_q  <= entry_d;
      sect_q   <= sect_d;
      words_q  <= words_d;
      wptr_q   <= wptr_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      scnt_q   <= scnt_d;
      ov_q     <= ov_d;
      okind_q  <= okind_d;
      oaddr_q  <= oaddr_d;
      odata_q  <= odata_d;
      oentry_q <= oentry_d;
      opass_q  <= opass_d;
      ocnt_q   <= ocnt_d;
      osum_q   <= osum_d;
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.kind          = okind_q;
  assign res_o.mem_addr      = oaddr_q;
  assign res_o.mem_data      = odata_q;
  assign res_o.entry_address = oentry_q;
  assign res_o.pass          = opass_q;
  assign res_o.local_count   = ocnt_q;
  assign res_o.local_sum     = osum_q;

  a_end_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && okind_q == sbil_pkg::KindEnd) |-> (oaddr_q == '0 && odata_q == '0))
    else $error("end report carries a memory address or data word");

  a_write_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && okind_q == sbil_pkg::KindWrite) |-> (!opass_q && ocnt_q == '0))
    else $error("memory write carries end report fields");

  a_data_words : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (words_q != '0))
    else $error("data phase entered with no words left");

endmodule

// File: rtl/core/serial_boot_image_loader.sv
// ----------------------------------------------------------------------------
// Serial boot image loader
// Packs serial bytes into words, parses the boot image and reports writes.
// ----------------------------------------------------------------------------
//   Channel  Direction  Request carries
//   rx_i     in         rx_byte, one received serial byte
//   res_o    out        kind, mem_addr, mem_data, entry_address, pass,
//                       local_count, local_sum
//
// One byte is taken per cycle, but a word's last byte waits while the queue is
// full; every fourth byte completes a word that enters the word queue. The
// parser retires one queued word per cycle unless a result waits on a stalled
// result channel. Reset clears the parse state and the queue. A stalled result
// channel holds the parser, and the front takes bytes until the queue fills.
module serial_boot_image_loader #(
  parameter int unsigned FifoDepth = sbil_pkg::FifoDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sbil_byte_if.sink     rx_i,
  sbil_result_if.source res_o
);

  sbil_pkg::word_req_t push;
  sbil_pkg::word_req_t head;
  logic                full;
  logic                pop;

  sbil_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .full_i (full),
    .push_o (push)
  );

  sbil_fifo #(
    .FifoDepth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  sbil_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial boot image loader testbench
// Streams boot images byte by byte into the loader, predicts every memory
// write and end-of-transfer report, and compares each report field by field
// under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxPrinted  = 40;

  typedef enum logic [2:0] {
    ImgEntry,
    ImgSectCount,
    ImgAddr,
    ImgSize,
    ImgData,
    ImgTrailCount,
    ImgTrailSum
  } img_phase_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] mem_addr;
    logic [31:0] mem_data;
    logic [31:0] entry_address;
    logic        pass;
    logic [31:0] local_count;
    logic [31:0] local_sum;
  } loader_report_t;

  logic clk_i;
  logic rst_ni;

  sbil_byte_if   rx_if ();
  sbil_result_if res_if ();

  serial_boot_image_loader u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  img_phase_e  img_phase     = ImgEntry;
  logic [1:0]  byte_pos      = '0;
  logic [31:0] word_acc      = '0;
  logic [31:0] entry_word    = '0;
  logic [31:0] sections_left = '0;
  logic [29:0] words_left    = '0;
  logic [31:0] write_ptr     = '0;
  logic [31:0] image_sum     = '0;
  logic [31:0] image_count   = '0;
  logic [31:0] sender_count  = '0;

  loader_report_t expected_reports[$];

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  function automatic void add_to_image(input logic [31:0] w);
    image_sum   += w;
    image_count += 32'd1;
  endfunction

  function automatic void close_section();
    sections_left -= 32'd1;
    img_phase = (sections_left == 32'd0) ? ImgTrailCount : ImgAddr;
  endfunction

  // Updates the image parse state with one accepted byte and queues the
  // report that the completed word causes, if any.
  task automatic track_rx_byte(input logic [7:0] b);
    logic [31:0]    w;
    loader_report_t rep;
    word_acc |= {24'h0, b} << {byte_pos, 3'b000};
    if (byte_pos != 2'd3) begin
      byte_pos += 2'd1;
    end else begin
      w        = word_acc;
      word_acc = '0;
      byte_pos = '0;
      rep      = '0;
      case (img_phase)
        ImgSectCount: begin
          add_to_image(w);
          sections_left = w;
          img_phase = (w == 32'd0) ? ImgTrailCount : ImgAddr;
        end
        ImgAddr: begin
          add_to_image(w);
          write_ptr = w;
          img_phase = ImgSize;
        end
        ImgSize: begin
          add_to_image(w);
          if (w[31] || w == 32'd0) begin
            words_left = '0;
            close_section();
          end else begin
            words_left = 30'((w + 32'd3) >> 2);
            img_phase  = ImgData;
          end
        end
        ImgData: begin
          add_to_image(w);
          rep.kind     = sbil_pkg::KindWrite;
          rep.mem_addr = write_ptr;
          rep.mem_data = w;
          expected_reports.push_back(rep);
          write_ptr  += 32'd4;
          words_left -= 30'd1;
          if (words_left == '0) begin
            close_section();
          end
        end
        ImgTrailCount: begin
          sender_count = w;
          img_phase    = ImgTrailSum;
        end
        ImgTrailSum: begin
          rep.kind          = sbil_pkg::KindEnd;
          rep.entry_address = entry_word;
          rep.pass          = (sender_count == image_count) && (w == image_sum);
          rep.local_count   = image_count;
          rep.local_sum     = image_sum;
          expected_reports.push_back(rep);
          img_phase     = ImgEntry;
          image_sum     = '0;
          image_count   = '0;
          sections_left = '0;
          words_left    = '0;
          sender_count  = '0;
        end
        default: begin
          image_sum   = '0;
          image_count = '0;
          add_to_image(w);
          entry_word = w;
          img_phase  = ImgSectCount;
        end
      endcase
    end
  endtask

  always @(posedge clk_i) begin : result_check
    loader_report_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected result, kind %b addr %h data %h",
                                  res_if.kind, res_if.mem_addr, res_if.mem_data));
      end else begin
        want = expected_reports.pop_front();
        check_field("kind", 32'(res_if.kind), 32'(want.kind));
        check_field("mem_addr", res_if.mem_addr, want.mem_addr);
        check_field("mem_data", res_if.mem_data, want.mem_data);
        check_field("entry_address", res_if.entry_address, want.entry_address);
        check_field("pass", 32'(res_if.pass), 32'(want.pass));
        check_field("local_count", res_if.local_count, want.local_count);
        check_field("local_sum", res_if.local_sum, want.local_sum);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following request keeps it up.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= 8'($urandom);
      @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (rx_if.ready !== 1'b1);
    track_rx_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      send_byte(w[8*i +: 8]);
    end
  endtask

  task automatic test_empty_image();
    logic [31:0] cnt;
    logic [31:0] sum;
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    cnt = image_count;
    sum = image_sum;
    send_word(cnt);
    send_word(sum);
    send_word(32'h0000_0000);
    send_word(32'h0000_0000);
    send_word(image_count + 32'd1);
    send_word(image_sum);
  endtask

  task automatic test_section_cases();
    send_word(32'h8000_0000);
    send_word(32'd4);
    // The first section wraps the write address and has a ragged size.
    send_word(32'hFFFF_FFF8);
    send_word(32'd9);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(32'hA5A5_A5A5);
    send_word(32'h0000_1000);
    send_word(32'h8000_0000);
    send_word(32'h0000_2000);
    send_word(32'h0000_0000);
    send_word(32'h0000_3000);
    send_word(32'hFFFF_FFFF);
    send_word(image_count);
    send_word(image_sum ^ 32'h0000_0001);
  endtask

  task automatic test_random_images(input int unsigned send_gap,
                                    input int unsigned recv_stall,
                                    input int unsigned budget);
    int unsigned stop_at;
    int unsigned nsect;
    int unsigned pick;
    logic [31:0] addr;
    logic [31:0] size;
    logic [31:0] cnt;
    logic [31:0] sum;
    gap_pct   = send_gap;
    stall_pct = recv_stall;
    stop_at   = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      nsect = $urandom_range(0, 3);
      send_word($urandom);
      send_word(nsect);
      for (int s = 0; s < nsect; s++) begin
        addr = $urandom;
        if ($urandom_range(0, 7) == 0) begin
          addr[31:4] = '1;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          size = '0;
        end else if (pick == 1) begin
          size = $urandom | 32'h8000_0000;
        end else begin
          size = $urandom_range(1, 24);
        end
        send_word(addr);
        send_word(size);
        if (!size[31]) begin
          for (int i = 0; i < (size + 3) / 4; i++) begin
            send_word($urandom);
          end
        end
      end
      cnt  = image_count;
      sum  = image_sum;
      pick = $urandom_range(0, 5);
      if (pick == 0) begin
        cnt += $urandom_range(1, 3);
      end else if (pick == 1) begin
        sum ^= 32'h1 << $urandom_range(0, 31);
      end else if (pick == 2) begin
        cnt = $urandom;
        sum = $urandom;
      end
      send_word(cnt);
      send_word(sum);
    end
  endtask

  task automatic test_line_noise();
    gap_pct   = 11;
    stall_pct = 11;
    for (int i = 0; i < 64; i++) begin
      send_byte(8'($urandom));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    res_if.ready  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_image();
    test_section_cases();
    test_random_images(0, 0, 250);
    test_random_images(80, 0, 250);
    test_random_images(0, 80, 250);
    test_random_images(11, 11, 250);
    test_line_noise();

    rx_if.valid <= 1'b0;
    stall_pct = 0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
